/* rtl/core/rcfd_pkg.sv */
// Shared types, frame constants and code tables for the remote command frame line driver.
// Used by every module of the block; no dependencies of its own.
package rcfd_pkg;

  localparam int unsigned BitTicksW   = 8;
  localparam int unsigned LongTicksW  = 16;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned DataW       = 16;
  localparam int unsigned FrameW      = 40;
  localparam int unsigned BitsLeftW   = 6;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

  localparam logic [7:0] FrameHead0 = 8'hD5;
  localparam logic [7:0] FrameHead1 = 8'hAA;
  localparam logic [7:0] FrameTail  = 8'hAD;

  localparam logic [BitsLeftW-1:0]  FrameBits        = BitsLeftW'(FrameW);
  localparam logic [BitTicksW-1:0]  BitTicksReset    = 8'd1;
  localparam logic [LongTicksW-1:0] SettleTicksReset = 16'd35;
  localparam logic [LongTicksW-1:0] GapTicksReset    = 16'd1000;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgBitTicks    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSettleTicks = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGapTicks    = 2'd2;

  // Item commands.
  localparam logic CmdTick = 1'b0;
  localparam logic CmdSend = 1'b1;

  // Function codes that carry the unit code.
  localparam logic [2:0] FnOn  = 3'd0;
  localparam logic [2:0] FnOff = 3'd1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_RESET  = 3'd1,
    PH_SETTLE = 3'd2,
    PH_PULSE  = 3'd3,
    PH_WAIT   = 3'd4,
    PH_GAP    = 3'd5
  } phase_e;

  // One classified word waiting between the front and the back.
  typedef struct packed {
    logic             send;
    logic [DataW-1:0] data;
  } rcfd_entry_t;

  // One result word.
  typedef struct packed {
    logic rts_level;
    logic dtr_level;
    logic busy_res;
    logic rejected;
  } rcfd_result_t;

  function automatic logic [DataW-1:0] house_word(input logic [3:0] house);
    logic [DataW-1:0] w;
    unique case (house)
      4'd0:  w = 16'h6000;
      4'd1:  w = 16'h7000;
      4'd2:  w = 16'h4000;
      4'd3:  w = 16'h5000;
      4'd4:  w = 16'h8000;
      4'd5:  w = 16'h9000;
      4'd6:  w = 16'hA000;
      4'd7:  w = 16'hB000;
      4'd8:  w = 16'hE000;
      4'd9:  w = 16'hF000;
      4'd10: w = 16'hC000;
      4'd11: w = 16'hD000;
      4'd12: w = 16'h0000;
      4'd13: w = 16'h1000;
      4'd14: w = 16'h2000;
      default: w = 16'h3000;
    endcase
    return w;
  endfunction

  function automatic logic [DataW-1:0] unit_word(input logic [3:0] unit);
    logic [DataW-1:0] w;
    unique case (unit)
      4'd0:  w = 16'h0000;
      4'd1:  w = 16'h0010;
      4'd2:  w = 16'h0008;
      4'd3:  w = 16'h0018;
      4'd4:  w = 16'h0040;
      4'd5:  w = 16'h0050;
      4'd6:  w = 16'h0048;
      4'd7:  w = 16'h0058;
      4'd8:  w = 16'h0400;
      4'd9:  w = 16'h0410;
      4'd10: w = 16'h0408;
      4'd11: w = 16'h0418;
      4'd12: w = 16'h0440;
      4'd13: w = 16'h0450;
      4'd14: w = 16'h0448;
      default: w = 16'h0458;
    endcase
    return w;
  endfunction

  function automatic logic [DataW-1:0] func_word(input logic [2:0] fn);
    logic [DataW-1:0] w;
    unique case (fn)
      3'd0: w = 16'h0000;
      3'd1: w = 16'h0020;
      3'd2: w = 16'h0088;
      3'd3: w = 16'h0098;
      3'd4: w = 16'h0080;
      3'd5: w = 16'h0091;
      3'd6: w = 16'h0084;
      default: w = 16'h0094;
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/rcfd_if.sv */
// Handshake channel interfaces for the remote command frame line driver.
// Depends on nothing; the send and result channels carry valid, ready and payload.
interface rcfd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [3:0] house_code;
  logic [3:0] unit_index;
  logic [2:0] function_code;

  modport source (output valid, command, house_code, unit_index, function_code,
                  input ready);
  modport sink   (input valid, command, house_code, unit_index, function_code,
                  output ready);
endinterface

interface rcfd_out_if;
  logic valid;
  logic ready;
  logic rts_level;
  logic dtr_level;
  logic busy_res;
  logic rejected;

  modport source (output valid, rts_level, dtr_level, busy_res, rejected,
                  input ready);
  modport sink   (input valid, rts_level, dtr_level, busy_res, rejected,
                  output ready);
endinterface

/* rtl/core/rcfd_front.sv */
// Front of the line driver: accepts input words and turns a send into its 16-bit data word.
// Depends on rcfd_pkg and the rcfd_in_if interface.
module rcfd_front
  import rcfd_pkg::*;
(
  rcfd_in_if.sink     in_s,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output rcfd_entry_t push_entry_o
);

  logic             has_unit;
  logic [DataW-1:0] unit_part;

  // Only on and off address a single unit.
  assign has_unit  = (in_s.function_code == FnOn) || (in_s.function_code == FnOff);
  assign unit_part = has_unit ? unit_word(in_s.unit_index) : '0;

  assign push_valid_o      = in_s.valid;
  assign in_s.ready        = push_ready_i;
  assign push_entry_o.send = (in_s.command == CmdSend);
  assign push_entry_o.data = house_word(in_s.house_code) | func_word(in_s.function_code)
                             | unit_part;

endmodule

/* rtl/core/rcfd_queue.sv */
// Short first-in first-out queue between the front and the back of the line driver.
// Depends on rcfd_pkg for the entry type and depth.
module rcfd_queue
  import rcfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  rcfd_entry_t push_entry_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output rcfd_entry_t pop_entry_o
);

  rcfd_entry_t          mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign push_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

/* rtl/core/rcfd_back.sv */
// Back of the line driver: the frame sequencer, the configuration registers and the result register.
// Depends on rcfd_pkg and the rcfd_out_if interface.
module rcfd_back
  import rcfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  rcfd_entry_t         pop_entry_i,
  rcfd_out_if.source          out_m
);

  logic [BitTicksW-1:0]  bit_ticks_q;
  logic [LongTicksW-1:0] settle_ticks_q, gap_ticks_q;

  phase_e                phase_q, phase_d;
  logic [FrameW-1:0]     frame_q, frame_d;
  logic [BitsLeftW-1:0]  bits_left_q, bits_left_d;
  logic [LongTicksW-1:0] timer_q, timer_d, timer_dec;
  logic                  rts_q, rts_d, dtr_q, dtr_d;
  logic                  rej_d;

  logic                  out_valid_q;
  rcfd_result_t          out_q;
  logic                  do_pop;

  logic [LongTicksW-1:0] bit_len, settle_len;

  // A zero length counts as one tick for the reset, pulse, wait and settle phases.
  assign bit_len    = (bit_ticks_q == '0) ? LongTicksW'(1)
                                          : LongTicksW'(bit_ticks_q);
  assign settle_len = (settle_ticks_q == '0) ? LongTicksW'(1) : settle_ticks_q;
  assign timer_dec  = (timer_q != '0) ? timer_q - 1'b1 : timer_q;

  assign pop_ready_o = !out_valid_q || out_m.ready;
  assign do_pop      = pop_valid_i && pop_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q    <= BitTicksReset;
      settle_ticks_q <= SettleTicksReset;
      gap_ticks_q    <= GapTicksReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBitTicks:    bit_ticks_q    <= cfg_data_i[BitTicksW-1:0];
        CfgSettleTicks: settle_ticks_q <= cfg_data_i;
        CfgGapTicks:    gap_ticks_q    <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  always_comb begin
    phase_d     = phase_q;
    frame_d     = frame_q;
    bits_left_d = bits_left_q;
    timer_d     = timer_q;
    rts_d       = rts_q;
    dtr_d       = dtr_q;
    rej_d       = 1'b0;
    if (pop_entry_i.send) begin
      if (phase_q != PH_IDLE) begin
        rej_d = 1'b1;
      end else begin
        frame_d     = {FrameHead0, FrameHead1, pop_entry_i.data, FrameTail};
        bits_left_d = FrameBits;
        rts_d       = 1'b0;
        dtr_d       = 1'b0;
        phase_d     = PH_RESET;
        timer_d     = bit_len;
      end
    end else if (phase_q != PH_IDLE) begin
      timer_d = timer_dec;
      if (timer_dec == '0) begin
        unique case (phase_q) inside
          PH_RESET: begin
            rts_d   = 1'b1;
            dtr_d   = 1'b1;
            phase_d = PH_SETTLE;
            timer_d = settle_len;
          end
          PH_PULSE: begin
            rts_d   = 1'b1;
            dtr_d   = 1'b1;
            phase_d = PH_WAIT;
            timer_d = bit_len;
          end
          PH_SETTLE, PH_WAIT: begin
            if (phase_q == PH_SETTLE || bits_left_q != '0) begin
              // Start the next bit: DTR drops for a one, RTS drops for a zero.
              rts_d       = frame_q[FrameW-1];
              dtr_d       = !frame_q[FrameW-1];
              frame_d     = {frame_q[FrameW-2:0], 1'b0};
              bits_left_d = (bits_left_q != '0) ? bits_left_q - 1'b1 : bits_left_q;
              phase_d     = PH_PULSE;
              timer_d     = bit_len;
            end else if (gap_ticks_q == '0) begin
              phase_d = PH_IDLE;
              timer_d = '0;
            end else begin
              phase_d = PH_GAP;
              timer_d = gap_ticks_q;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            timer_d = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      frame_q     <= '0;
      bits_left_q <= '0;
      timer_q     <= '0;
      rts_q       <= 1'b0;
      dtr_q       <= 1'b0;
    end else if (do_pop) begin
      phase_q     <= phase_d;
      frame_q     <= frame_d;
      bits_left_q <= bits_left_d;
      timer_q     <= timer_d;
      rts_q       <= rts_d;
      dtr_q       <= dtr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      out_valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      out_q.rts_level <= rts_d;
      out_q.dtr_level <= dtr_d;
      out_q.busy_res  <= (phase_d != PH_IDLE);
      out_q.rejected  <= rej_d;
    end
  end

  assign out_m.valid     = out_valid_q;
  assign out_m.rts_level = out_q.rts_level;
  assign out_m.dtr_level = out_q.dtr_level;
  assign out_m.busy_res  = out_q.busy_res;
  assign out_m.rejected  = out_q.rejected;

  // A rejected send leaves the frame running, so its result must report busy.
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.rejected |-> out_q.busy_res)
    else $error("rejected result without busy");

  // The phase timer is always cleared when the sequencer is idle.
  a_idle_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> timer_q == '0)
    else $error("timer running while idle");

  // During a bit pulse exactly one of the two lines is low.
  a_pulse_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PULSE |-> rts_q != dtr_q)
    else $error("pulse drives both lines alike");

  // The bit counter never exceeds the frame length.
  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_left_q <= FrameBits)
    else $error("bit counter out of range");

endmodule

/* rtl/core/remote_command_frame_line_driver.sv */
// Top level of the remote command frame line driver.
// Depends on rcfd_pkg, rcfd_if, rcfd_front, rcfd_queue and rcfd_back.
//
// Usage: every word on the in_s channel is either a tick (command 0), which advances
// time by one tick, or a send (command 1), which starts a 40-bit frame built from the
// house, unit and function codes. Every accepted word yields exactly one result word on
// out_m with the RTS and DTR levels after that word, a busy flag and a rejected flag
// that is set when a send arrives while a frame or its closing gap is still running.
// The configuration port writes bit_ticks, settle_ticks and gap_ticks at any edge where
// cfg_we_i is high; it should only be used while no word is waiting in the queue or the
// result register. A write during a frame takes effect at the next timer load.
//
// Flow and throughput: a word is accepted whenever the four-entry queue has room. It is
// held in the queue until the back takes it, which it does when the result register is
// free or being read, and its result word is then registered for out_m. The back handles
// one queued word per cycle while out_m.ready is high, so one word per cycle is sustained.
//
// At reset the lines are low, the sequencer is idle and the registers take their
// default values. When the receiver holds ready low, the result register keeps its word,
// the back stops draining the queue, and the front keeps accepting until the queue fills.
module remote_command_frame_line_driver
  import rcfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  rcfd_in_if.sink             in_s,
  rcfd_out_if.source          out_m,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic        push_valid, push_ready;
  rcfd_entry_t push_entry;
  logic        pop_valid, pop_ready;
  rcfd_entry_t pop_entry;

  // The front classifies each word and looks up the data word of a send.
  rcfd_front u_front (
    .in_s         (in_s),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // The queue lets the front keep accepting while the result side is stalled.
  rcfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // The back runs the reset, settle, bit and gap phases and registers each result.
  rcfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_m       (out_m)
  );

endmodule
